// ===== rtl/texel_color_modulate_blend_assert.svh =====
// ---------------------------------------------------------------------------
// texel_color_modulate_blend assertion macros
// Shared property templates for the block's checker.
// ---------------------------------------------------------------------------
`ifndef TEXEL_COLOR_MODULATE_BLEND_ASSERT_SVH
`define TEXEL_COLOR_MODULATE_BLEND_ASSERT_SVH

// Same-cycle implication, off during reset.
`define TCMB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tcmb assertion failed");

// Next-cycle implication, off during reset.
`define TCMB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tcmb assertion failed");

// Next-cycle implication, always on (for reset behavior).
`define TCMB_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("tcmb assertion failed");

`endif

// ===== rtl/tcmb_pkg.sv =====
// ---------------------------------------------------------------------------
// tcmb_pkg
// Types, constants and arithmetic helpers for the texel modulate/blend block.
// ---------------------------------------------------------------------------
`default_nettype none

package tcmb_pkg;

    localparam int COORD_BITS   = 12;
    localparam int DIM_BITS     = 13;
    localparam int CH_BITS      = 8;
    localparam int NUM_CH       = 4;
    localparam int NUM_CORNERS  = 4;
    localparam int ALPHA_CH     = 3;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int CMP_BITS     = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;

    // 0.16 weights; 1.0 needs the extra bit
    localparam int Q_BITS         = 16;
    localparam int WGT_BITS       = Q_BITS + 1;
    localparam int BLEND_SUM_BITS = CH_BITS + Q_BITS;
    localparam logic [WGT_BITS-1:0] ONE_Q16 = WGT_BITS'(1) << Q_BITS;

    // Pipeline layout
    localparam int DIV_STAGES   = 4;
    localparam int DIV_STEPS    = Q_BITS / DIV_STAGES;
    localparam int ST_DIV_FIRST = 1;
    localparam int ST_DIV_LAST  = DIV_STAGES;
    localparam int ST_LERP_V    = DIV_STAGES + 1;
    localparam int ST_LERP_H    = DIV_STAGES + 2;
    localparam int ST_OUT       = DIV_STAGES + 3;
    localparam int PIPE_DEPTH   = DIV_STAGES + 4;

    // Corner slots in the color table
    localparam int COR_LR = 0;
    localparam int COR_LL = 1;
    localparam int COR_UL = 2;
    localparam int COR_UR = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_DRAW_MODE = 3'd0,
        REG_COLOR_LR  = 3'd1,
        REG_COLOR_LL  = 3'd2,
        REG_COLOR_UL  = 3'd3,
        REG_COLOR_UR  = 3'd4,
        REG_AREA_W    = 3'd5,
        REG_AREA_H    = 3'd6
    } t_reg_idx;

    // Color mode, draw_mode[2:1]; code 3 behaves as plain
    typedef enum logic [1:0] {
        CM_PLAIN  = 2'd0,
        CM_SINGLE = 2'd1,
        CM_CORNER = 2'd2
    } t_cmode;

    typedef logic [NUM_CH-1:0][CH_BITS-1:0] t_rgba;

    typedef struct packed {
        logic [2:0]                   draw_mode;
        logic [NUM_CORNERS-1:0][NUM_CH-1:0][CH_BITS-1:0] color;
        logic [DIM_BITS-1:0]          area_width;
        logic [DIM_BITS-1:0]          area_height;
    } t_cfg;

    typedef struct packed {
        logic [COORD_BITS-1:0] texel_col;
        logic [COORD_BITS-1:0] texel_row;
        logic [CH_BITS-1:0]    src_ch0;
        logic [CH_BITS-1:0]    src_ch1;
        logic [CH_BITS-1:0]    src_ch2;
        logic [CH_BITS-1:0]    src_alpha;
        logic [CH_BITS-1:0]    dst_ch0;
        logic [CH_BITS-1:0]    dst_ch1;
        logic [CH_BITS-1:0]    dst_ch2;
        logic [CH_BITS-1:0]    dst_alpha;
    } t_in_item;

    typedef struct packed {
        logic [CH_BITS-1:0] out_ch0;
        logic [CH_BITS-1:0] out_ch1;
        logic [CH_BITS-1:0] out_ch2;
        logic [CH_BITS-1:0] out_alpha;
        logic               write_enable;
    } t_out_item;

    // Texel and destination bytes riding down the pipe
    typedef struct packed {
        t_rgba src;
        t_rgba dst;
    } t_pix;

    // One restoring-division step: {quotient bit, new remainder}. rem < d.
    function automatic logic [DIM_BITS:0] div_step(
        input logic [DIM_BITS-1:0] rem,
        input logic [DIM_BITS-1:0] d
    );
        logic [DIM_BITS:0] t;
        logic [DIM_BITS:0] diff;
        t    = {rem, 1'b0};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            return {1'b1, diff[DIM_BITS-1:0]};
        end else begin
            return {1'b0, t[DIM_BITS-1:0]};
        end
    endfunction

    // (a*w + b*(1-w)) >> 16, truncated
    function automatic logic [CH_BITS-1:0] blend_q16(
        input logic [CH_BITS-1:0]  a,
        input logic [CH_BITS-1:0]  b,
        input logic [WGT_BITS-1:0] w
    );
        logic [WGT_BITS-1:0]       wc;
        logic [BLEND_SUM_BITS-1:0] s;
        wc = ONE_Q16 - w;
        s  = BLEND_SUM_BITS'(a) * BLEND_SUM_BITS'(w)
           + BLEND_SUM_BITS'(b) * BLEND_SUM_BITS'(wc);
        return s[BLEND_SUM_BITS-1:Q_BITS];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tcmb_cfg.sv =====
// ---------------------------------------------------------------------------
// tcmb_cfg
// Configuration register file: draw mode, corner colors, area size.
// ---------------------------------------------------------------------------
`default_nettype none

module tcmb_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr,
    input  logic [tcmb_pkg::CFG_IDX_BITS-1:0]  i_index,
    input  logic [tcmb_pkg::CFG_DATA_BITS-1:0] i_data,
    output tcmb_pkg::t_cfg                    o_cfg
);
    import tcmb_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.draw_mode   <= '0;
            r_cfg.color       <= '1;
            r_cfg.area_width  <= DIM_BITS'(1);
            r_cfg.area_height <= DIM_BITS'(1);
        end else if (i_wr) begin
            unique case (i_index)
                REG_DRAW_MODE: r_cfg.draw_mode      <= i_data[2:0];
                REG_COLOR_LR:  r_cfg.color[COR_LR]  <= i_data;
                REG_COLOR_LL:  r_cfg.color[COR_LL]  <= i_data;
                REG_COLOR_UL:  r_cfg.color[COR_UL]  <= i_data;
                REG_COLOR_UR:  r_cfg.color[COR_UR]  <= i_data;
                REG_AREA_W:    r_cfg.area_width     <= i_data[DIM_BITS-1:0];
                REG_AREA_H:    r_cfg.area_height    <= i_data[DIM_BITS-1:0];
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/tcmb_wdiv.sv =====
// ---------------------------------------------------------------------------
// tcmb_wdiv
// Pipelined 0.16 weight divider: floor(coord * 65536 / dim), saturating at 1.0.
// ---------------------------------------------------------------------------
`default_nettype none

module tcmb_wdiv (
    input  logic                              i_clk,
    input  logic [tcmb_pkg::DIV_STAGES-1:0]   i_adv,
    input  logic [tcmb_pkg::COORD_BITS-1:0]   i_coord,
    input  logic [tcmb_pkg::DIM_BITS-1:0]     i_dim,
    output logic [tcmb_pkg::WGT_BITS-1:0]     o_weight
);
    import tcmb_pkg::*;

    logic [DIM_BITS-1:0] d_eff;
    logic [CMP_BITS-1:0] c_ext;
    logic [CMP_BITS-1:0] d_ext;

    logic [DIM_BITS-1:0] in_rem [DIV_STAGES];
    logic [Q_BITS-1:0]   in_q   [DIV_STAGES];
    logic [DIV_STAGES-1:0] in_sat;

    logic [DIM_BITS-1:0] n_rem [DIV_STAGES];
    logic [Q_BITS-1:0]   n_q   [DIV_STAGES];
    logic [DIM_BITS:0]   step_t;

    logic [DIM_BITS-1:0] r_rem [DIV_STAGES];
    logic [Q_BITS-1:0]   r_q   [DIV_STAGES];
    logic [DIV_STAGES-1:0] r_sat;

    // zero size acts as one; a coordinate at or past the size saturates
    always_comb begin
        d_eff = (i_dim == '0) ? DIM_BITS'(1) : i_dim;
        c_ext = CMP_BITS'(i_coord);
        d_ext = CMP_BITS'(d_eff);
    end

    always_comb begin
        in_rem[0] = c_ext[DIM_BITS-1:0];
        in_q[0]   = '0;
        in_sat[0] = (c_ext >= d_ext);
        for (int s = 1; s < DIV_STAGES; s++) begin
            in_rem[s] = r_rem[s-1];
            in_q[s]   = r_q[s-1];
            in_sat[s] = r_sat[s-1];
        end
    end

    // DIV_STEPS quotient bits per stage, MSB first
    always_comb begin
        step_t = '0;
        for (int s = 0; s < DIV_STAGES; s++) begin
            n_rem[s] = in_rem[s];
            n_q[s]   = in_q[s];
            for (int j = 0; j < DIV_STEPS; j++) begin
                step_t   = div_step(n_rem[s], d_eff);
                n_rem[s] = step_t[DIM_BITS-1:0];
                n_q[s]   = {n_q[s][Q_BITS-2:0], step_t[DIM_BITS]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (i_adv[s]) begin
                r_rem[s] <= n_rem[s];
                r_q[s]   <= n_q[s];
                r_sat[s] <= in_sat[s];
            end
        end
    end

    assign o_weight = r_sat[DIV_STAGES-1] ? ONE_Q16 : {1'b0, r_q[DIV_STAGES-1]};

endmodule

`default_nettype wire

// ===== rtl/tcmb_corner.sv =====
// ---------------------------------------------------------------------------
// tcmb_corner
// Two-stage corner color interpolation: vertical pair, then horizontal.
// ---------------------------------------------------------------------------
`default_nettype none

module tcmb_corner (
    input  logic                          i_clk,
    input  logic [1:0]                    i_adv,
    input  tcmb_pkg::t_cfg                i_cfg,
    input  logic [tcmb_pkg::WGT_BITS-1:0] i_hw,
    input  logic [tcmb_pkg::WGT_BITS-1:0] i_vw,
    output tcmb_pkg::t_rgba               o_color
);
    import tcmb_pkg::*;

    t_rgba               n_left;
    t_rgba               n_right;
    t_rgba               n_color;
    t_rgba               r_left;
    t_rgba               r_right;
    t_rgba               r_color;
    logic [WGT_BITS-1:0] r_hw;

    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            n_left[k]  = blend_q16(i_cfg.color[COR_UL][k], i_cfg.color[COR_LL][k], i_vw);
            n_right[k] = blend_q16(i_cfg.color[COR_UR][k], i_cfg.color[COR_LR][k], i_vw);
            n_color[k] = blend_q16(r_left[k], r_right[k], r_hw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_left  <= n_left;
            r_right <= n_right;
            r_hw    <= i_hw;
        end
        if (i_adv[1]) begin
            r_color <= n_color;
        end
    end

    assign o_color = r_color;

endmodule

`default_nettype wire

// ===== rtl/tcmb_mix.sv =====
// ---------------------------------------------------------------------------
// tcmb_mix
// Texel modulation and destination blend; drives the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module tcmb_mix (
    input  logic                i_clk,
    input  logic                i_adv,
    input  tcmb_pkg::t_cfg      i_cfg,
    input  tcmb_pkg::t_rgba     i_color,
    input  tcmb_pkg::t_pix      i_pix,
    output tcmb_pkg::t_out_item o_item
);
    import tcmb_pkg::*;

    t_cmode                 mode;
    logic                   blend_on;
    t_rgba                  modv;
    t_rgba                  res;
    logic                   we;
    logic [2*CH_BITS-1:0]   prod [NUM_CH];
    t_out_item              n_item;
    t_out_item              r_item;

    always_comb begin
        mode     = t_cmode'(i_cfg.draw_mode[2:1]);
        blend_on = i_cfg.draw_mode[0];
        for (int k = 0; k < NUM_CH; k++) begin
            prod[k] = '0;
            unique case (mode)
                CM_SINGLE: begin
                    prod[k] = (2*CH_BITS)'(i_pix.src[k])
                            * (2*CH_BITS)'(i_cfg.color[COR_LR][k]);
                    modv[k] = prod[k][2*CH_BITS-1:CH_BITS];
                end
                CM_CORNER: begin
                    prod[k] = (2*CH_BITS)'(i_pix.src[k]) * (2*CH_BITS)'(i_color[k]);
                    modv[k] = prod[k][2*CH_BITS-1:CH_BITS];
                end
                default: modv[k] = i_pix.src[k];  // plain, and the unused code
            endcase
        end

        priority if (!blend_on) begin
            res = modv;
            we  = 1'b1;
        end else if (modv[ALPHA_CH] == '0) begin
            res = i_pix.dst;            // transparent texel: no write
            we  = 1'b0;
        end else if (i_pix.dst[ALPHA_CH] == '0) begin
            res = modv;
            we  = 1'b1;
        end else begin
            for (int k = 0; k < NUM_CH; k++) begin
                res[k] = (modv[k] > i_pix.dst[k]) ? modv[k] : i_pix.dst[k];
            end
            we = 1'b1;
        end

        n_item.out_ch0      = res[0];
        n_item.out_ch1      = res[1];
        n_item.out_ch2      = res[2];
        n_item.out_alpha    = res[ALPHA_CH];
        n_item.write_enable = we;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

`default_nettype wire

// ===== rtl/texel_color_modulate_blend.sv =====
// ---------------------------------------------------------------------------
// texel_color_modulate_blend
// Texel color modulation (plain / single color / four-corner gradient) with
// max blending against the current destination pixel.
//
//   channel  direction  handshake              payload
//   in       sink       i_in_valid/o_in_stall  i_in_data  (t_in_item)
//   out      source     o_out_valid/i_out_stall o_out_data (t_out_item)
//   cfg      sink       i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// Throughput one transfer per clock while the output is not stalled. The
// pipe holds the input register, the 16-bit weight quotient at 4 bits per
// stage over 4 stages, two interpolation stages and the modulate/blend
// output register.
// Reset (synchronous) empties the pipe; no clearing pass.
// Output stall freezes only full stages; bubbles close up, so the input is
// stalled only when every stage holds an item and the output is stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module texel_color_modulate_blend (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  tcmb_pkg::t_in_item                 i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output tcmb_pkg::t_out_item                o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tcmb_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [tcmb_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import tcmb_pkg::*;

    t_cfg                  cfg;
    logic [PIPE_DEPTH-1:0] go;        // stage k loads this cycle
    logic [PIPE_DEPTH-1:0] r_vld;
    t_in_item              r_in;      // stage 0
    t_pix                  r_pix [ST_DIV_FIRST:ST_LERP_H];
    t_pix                  n_pix0;
    logic [WGT_BITS-1:0]   hw;
    logic [WGT_BITS-1:0]   vw;
    t_rgba                 color;

    // Config: always ready; the user must write registers only while idle, which the block does not enforce
    assign o_cfg_ready = 1'b1;

    tcmb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // Stage advance: a stage loads when empty or when the one after it moves
    always_comb begin
        go[PIPE_DEPTH-1] = !r_vld[PIPE_DEPTH-1] || !i_out_stall;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
            go[k] = !r_vld[k] || go[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (go[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                if (go[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_stall  = !go[0];
    assign o_out_valid = r_vld[ST_OUT];

    // Input register and the pixel bytes that ride alongside the math
    always_comb begin
        n_pix0.src = {r_in.src_alpha, r_in.src_ch2, r_in.src_ch1, r_in.src_ch0};
        n_pix0.dst = {r_in.dst_alpha, r_in.dst_ch2, r_in.dst_ch1, r_in.dst_ch0};
    end

    always_ff @(posedge i_clk) begin
        if (go[0]) begin
            r_in <= i_in_data;
        end
        if (go[ST_DIV_FIRST]) begin
            r_pix[ST_DIV_FIRST] <= n_pix0;
        end
        for (int k = ST_DIV_FIRST + 1; k <= ST_LERP_H; k++) begin
            if (go[k]) begin
                r_pix[k] <= r_pix[k-1];
            end
        end
    end

    // Horizontal and vertical weights, stages 1..4
    tcmb_wdiv u_wdiv_h (
        .i_clk    (i_clk),
        .i_adv    (go[ST_DIV_LAST:ST_DIV_FIRST]),
        .i_coord  (r_in.texel_col),
        .i_dim    (cfg.area_width),
        .o_weight (hw)
    );

    tcmb_wdiv u_wdiv_v (
        .i_clk    (i_clk),
        .i_adv    (go[ST_DIV_LAST:ST_DIV_FIRST]),
        .i_coord  (r_in.texel_row),
        .i_dim    (cfg.area_height),
        .o_weight (vw)
    );

    // Corner gradient, stages 5..6
    tcmb_corner u_corner (
        .i_clk   (i_clk),
        .i_adv   ({go[ST_LERP_H], go[ST_LERP_V]}),
        .i_cfg   (cfg),
        .i_hw    (hw),
        .i_vw    (vw),
        .o_color (color)
    );

    // Modulate and blend into the output register, stage 7
    tcmb_mix u_mix (
        .i_clk   (i_clk),
        .i_adv   (go[ST_OUT]),
        .i_cfg   (cfg),
        .i_color (color),
        .i_pix   (r_pix[ST_LERP_H]),
        .o_item  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== rtl/tcmb_chk.sv =====
// ---------------------------------------------------------------------------
// tcmb_chk
// Port-level checker for texel_color_modulate_blend, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "texel_color_modulate_blend_assert.svh"

module tcmb_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input tcmb_pkg::t_out_item o_out_data
);
    import tcmb_pkg::*;

    // a stalled result holds
    `TCMB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // input backs up only behind a stalled, waiting result
    `TCMB_ASSERT_IMPLY(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

    // an empty output stage never blocks a new transfer
    `TCMB_ASSERT_IMPLY(a_empty_takes, i_clk, i_rst_n, i_in_valid && !o_out_valid, !o_in_stall)

    // reset empties the pipe
    `TCMB_ASSERT_NEXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !o_out_valid)

endmodule

bind texel_color_modulate_blend tcmb_chk u_tcmb_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
